// File: rtl/iopvd_pkg.sv
package iopvd_pkg;

    // Bus access kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACC_IO_WR  = 2'd0,
        ACC_IO_RD  = 2'd1,
        ACC_MEM_WR = 2'd2,
        ACC_NONE   = 2'd3
    } acc_kind_t;

    // Command queue between decode and execute
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic CFG_IDX_FRAME_LEN = 1'b0;

    // Field widths
    localparam int DATA_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int FRAME_W = 16;
    localparam int FBI_W   = 14;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    // Fixed values
    localparam logic [7:0]  VRAM_HI_MIN   = 8'hD8;
    localparam logic [7:0]  IO_READ_DATA  = 8'hFF;
    localparam logic [7:0]  LINE_RESET    = 8'hFF;
    localparam logic [15:0] FRAME_LEN_RST = 16'd39936;
    localparam logic [15:0] FRAME_BASE    = 16'(57 * 128);

    // Decoded bus access
    typedef struct packed {
        acc_kind_t  kind;
        logic       wr_control;  // port bit 3 low
        logic       wr_audio;    // port bit 0 low
        logic       wr_sound;    // port bit 1 low
        logic [7:0] port_rot;    // low address byte rotated left by one
        logic [7:0] col_rev;     // 255 minus the high address byte
        logic       in_window;   // address inside the displayed video RAM
        logic [7:0] data;
    } cmd_t;

    // One result transaction
    typedef struct packed {
        logic [7:0]  data_out;
        logic [13:0] fb_index;
        logic        fb_write;
        logic        snd_strobe;
        logic        tape_level;
        logic        tape_motor;
        logic [2:0]  audio_select;
        logic [15:0] frame_ticks;
        logic        dma_on;
        logic        io_mapped;
        logic        rom_mapped;
        logic [7:0]  read_data;
    } result_t;

endpackage

// File: rtl/iopvd_front.sv
module iopvd_front #(
    parameter int COLUMNS = 40
) (
    input  logic [1:0]                  func,
    input  logic [iopvd_pkg::ADDR_W-1:0] addr,
    input  logic [iopvd_pkg::DATA_W-1:0] data,
    output iopvd_pkg::cmd_t             cmd
);

    localparam logic [8:0] HI_MIN_COL = 9'(256 - COLUMNS);

    logic [7:0] port_byte;
    logic [7:0] hi_byte;

    assign port_byte = addr[7:0];
    assign hi_byte   = addr[15:8];

    // Classify the access and pre-decode the port and address bits
    always_comb begin
        cmd.kind       = iopvd_pkg::acc_kind_t'(func);
        cmd.wr_control = ~port_byte[3];
        cmd.wr_audio   = ~port_byte[0];
        cmd.wr_sound   = ~port_byte[1];
        cmd.port_rot   = {port_byte[6:0], port_byte[7]};
        cmd.col_rev    = ~hi_byte;
        cmd.in_window  = (hi_byte >= iopvd_pkg::VRAM_HI_MIN)
                         && ({1'b0, hi_byte} >= HI_MIN_COL);
        cmd.data       = data;
    end

endmodule

// File: rtl/iopvd_queue.sv
module iopvd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  iopvd_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output iopvd_pkg::cmd_t pop_cmd
);

    iopvd_pkg::cmd_t                  slot_reg [iopvd_pkg::QUEUE_DEPTH];
    logic [iopvd_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [iopvd_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [iopvd_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == iopvd_pkg::QCNT_W'(iopvd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/iopvd_back.sv
module iopvd_back #(
    parameter int COLUMNS = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  iopvd_pkg::cmd_t               cmd,
    output logic                          cmd_pop,
    input  logic [iopvd_pkg::FRAME_W-1:0] frame_len_cfg,
    output logic                          res_valid,
    output iopvd_pkg::result_t            res,
    input  logic                          res_ready
);

    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] audio_reg, audio_next;
    logic [7:0] line_reg, line_next;
    logic       dma_en_reg, dma_en_next;
    logic       timing_reg, timing_next;

    logic               res_valid_reg;
    iopvd_pkg::result_t res_reg, res_next;

    logic [iopvd_pkg::FBI_W-1:0] row_off;
    logic [iopvd_pkg::FBI_W-1:0] fb_offset;

    assign cmd_pop   = cmd_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Framebuffer offset of the addressed byte
    assign row_off   = iopvd_pkg::FBI_W'(line_reg - cmd.port_rot);
    assign fb_offset = row_off * iopvd_pkg::FBI_W'(COLUMNS) + iopvd_pkg::FBI_W'(cmd.col_rev);

    // Execute one access against the port latches
    always_comb begin
        ctrl_next   = ctrl_reg;
        audio_next  = audio_reg;
        line_next   = line_reg;
        dma_en_next = dma_en_reg;
        timing_next = timing_reg;
        res_next    = '0;

        case (cmd.kind)
            iopvd_pkg::ACC_IO_WR: begin
                res_next.data_out = cmd.data;
                if (cmd.wr_control) begin
                    ctrl_next   = cmd.data;
                    dma_en_next = cmd.data[0];
                    timing_next = cmd.data[0];
                end
                if (cmd.wr_audio) begin
                    audio_next = cmd.data;
                end
                res_next.snd_strobe = cmd.wr_sound && audio_next[3];
            end
            iopvd_pkg::ACC_IO_RD: begin
                res_next.read_data = iopvd_pkg::IO_READ_DATA;
                if (ctrl_reg[5:4] == 2'b00) begin
                    line_next = cmd.port_rot;
                end
            end
            iopvd_pkg::ACC_MEM_WR: begin
                res_next.data_out = cmd.data;
                if (cmd.in_window && dma_en_reg && (cmd.port_rot != '0)
                    && (cmd.port_rot <= line_reg)) begin
                    res_next.fb_write = 1'b1;
                    res_next.fb_index = fb_offset;
                end
            end
            default: begin
            end
        endcase

        // Report state as left by the access
        res_next.rom_mapped   = ~ctrl_next[1];
        res_next.io_mapped    = ctrl_next[2];
        res_next.tape_level   = ctrl_next[3];
        res_next.dma_on       = dma_en_next;
        res_next.audio_select = audio_next[7:5];
        res_next.tape_motor   = audio_next[4];
        res_next.frame_ticks  = timing_next
            ? iopvd_pkg::FRAME_BASE + {1'b0, ~line_next, 7'b0}
            : frame_len_cfg;
    end

    // Commit state on every executed access
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg      <= '0;
            audio_reg     <= '0;
            line_reg      <= iopvd_pkg::LINE_RESET;
            dma_en_reg    <= 1'b1;
            timing_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (cmd_pop) begin
                ctrl_reg   <= ctrl_next;
                audio_reg  <= audio_next;
                line_reg   <= line_next;
                dma_en_reg <= dma_en_next;
                timing_reg <= timing_next;
            end
            if (cmd_pop) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            res_reg <= res_next;
        end
    end

endmodule

// File: rtl/io_port_and_video_dma_map.sv
// Channel   Ports                       Transaction
// input     s_tvalid/s_tready/s_t*      one bus access: kind in tuser, addr and data in tdata
// output    m_tvalid/m_tready/m_tdata   port state and strobes after that access
// config    psel/penable/pwrite/paddr   frame length register at byte address 0
// One access per cycle sustained while m_tready stays high; a taken access reaches m_* once
// decode has written it into a four-entry queue and one execute stage into the output register.
// Reset (aresetn low, synchronous) empties the queue and loads the port latches.
// A stalled m_tready fills the queue; s_tready drops only when all four entries are held.
module io_port_and_video_dma_map #(
    parameter int COLUMNS = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [iopvd_pkg::S_TDATA_W-1:0]     s_tdata,  // addr[15:0], data[23:16]
    input  logic [1:0]                          s_tuser,  // func[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_data[7:0], rom_mapped[8], io_mapped[9], dma_on[10], frame_ticks[26:11],
    // audio_select[29:27], tape_motor[30], tape_level[31], sound strobe[32],
    // fb_write[33], fb_index[47:34], data_out[55:48]
    output logic [iopvd_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iopvd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [iopvd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [iopvd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);

    logic [iopvd_pkg::FRAME_W-1:0] frame_len_reg;
    logic                          cfg_wr;
    logic                          cfg_hit;

    iopvd_pkg::cmd_t    dec_cmd;
    iopvd_pkg::cmd_t    q_cmd;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               push;
    iopvd_pkg::result_t res;

    // Register access
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == iopvd_pkg::CFG_IDX_FRAME_LEN);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? iopvd_pkg::CFG_DATA_W'(frame_len_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg <= iopvd_pkg::FRAME_LEN_RST;
        end else if (cfg_wr) begin
            frame_len_reg <= pwdata[iopvd_pkg::FRAME_W-1:0];
        end
    end

    // Decode incoming accesses
    iopvd_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .func (s_tuser),
        .addr (s_tdata[15:0]),
        .data (s_tdata[23:16]),
        .cmd  (dec_cmd)
    );

    assign s_tready = ~q_full;
    assign push     = s_tvalid && s_tready;

    iopvd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (dec_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (q_cmd)
    );

    // Execute accesses and hold results
    iopvd_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_valid),
        .cmd           (q_cmd),
        .cmd_pop       (q_pop),
        .frame_len_cfg (frame_len_reg),
        .res_valid     (m_tvalid),
        .res           (res),
        .res_ready     (m_tready)
    );

    assign m_tdata = res;

endmodule
